// ----- hdl/c3f_pkg.sv -----
// c3f_pkg: shared types and constants of the 3x3 image convolution filter
// no dependencies; imported by the top level, its bound checker and the testbench
`default_nettype none

package c3f_pkg;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int MASK_W         = 24;
  localparam int COEF_W         = 8;
  localparam int OUT_W          = 20;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 24;

  localparam int WIN_DIM  = 3;
  localparam int WIN_SIZE = WIN_DIM * WIN_DIM;
  localparam int MIN_DIM  = 3;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_AW + 1;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd8;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 16'd8;
  localparam logic [MASK_W-1:0]         MASK_RESET         = 24'h010101;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_MASK_TOP     = 3'd2,
    REG_MASK_MIDDLE  = 3'd3,
    REG_MASK_BOTTOM  = 3'd4
  } cfg_reg_e;

  // signed coefficient k of a packed mask row, left one in the low byte
  function automatic logic signed [COEF_W-1:0] mask_coef(input logic [MASK_W-1:0] row,
                                                        input logic [1:0] k);
    return $signed(row[k*COEF_W +: COEF_W]);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/c3f_ram.sv -----
// c3f_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
`default_nettype none

module c3f_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/conv3x3_image_filter_top.sv -----
// conv3x3_image_filter_top: raster-order 3x3 weighted neighborhood sum
// depends on c3f_pkg and c3f_ram
//
// Takes one pixel item per clock and keeps taking one per clock for as long as results are
// drained. The two previous image lines live in a single RAM of MAX_LINE_WIDTH entries of two
// pixels each: the entry of the current column is read when the pixel is accepted and written
// back in the following cycle, with a bypass when the next pixel hits the same column. The
// result of each interior pixel is registered through the window update, products and row sums,
// and the total of its row sums is pushed into the output queue. An eight-entry result queue parts
// the pipeline from the output, so input stalls only while that queue and the results still in
// the pipeline add up to eight. The line RAM needs no clearing pass after reset.
`default_nettype none

module conv3x3_image_filter_top
  import c3f_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int PIXEL_BITS     = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [PIXEL_BITS-1:0]  pixel_i,
  input  wire logic                   start_of_frame_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [OUT_W-1:0]       filtered_value_o,
  output logic                        last_of_frame_o
);

  localparam int ColW  = $clog2(MAX_LINE_WIDTH);
  localparam int WW    = (ColW + 1 > FRAME_WIDTH_W) ? ColW + 1 : FRAME_WIDTH_W;
  localparam int LineW = 2 * PIXEL_BITS;
  localparam int ProdW = PIXEL_BITS + COEF_W + 1;
  localparam int RowW  = ProdW + 2;
  localparam int SumW  = RowW + 2;

  // configuration registers
  logic [FRAME_WIDTH_W-1:0]  frame_width_q;
  logic [FRAME_HEIGHT_W-1:0] frame_height_q;
  logic [MASK_W-1:0]         mask_q [WIN_DIM];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RESET;
      frame_height_q <= FRAME_HEIGHT_RESET;
      for (int j = 0; j < WIN_DIM; j++) begin
        mask_q[j] <= MASK_RESET;
      end
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FRAME_HEIGHT_W-1:0];
        REG_MASK_TOP:     mask_q[0]      <= cfg_data_i[MASK_W-1:0];
        REG_MASK_MIDDLE:  mask_q[1]      <= cfg_data_i[MASK_W-1:0];
        REG_MASK_BOTTOM:  mask_q[2]      <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame geometry
  logic [WW-1:0]             w_ext, w_eff;
  logic [ColW-1:0]           w_last;
  logic [FRAME_HEIGHT_W-1:0] h_last;

  always_comb begin
    w_ext = WW'(frame_width_q);
    if (w_ext < WW'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (w_ext > WW'(MAX_LINE_WIDTH)) begin
      w_eff = WW'(MAX_LINE_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    w_last = ColW'(w_eff - WW'(1));
    if (frame_height_q < FRAME_HEIGHT_W'(MIN_DIM)) begin
      h_last = FRAME_HEIGHT_W'(MIN_DIM - 1);
    end else begin
      h_last = frame_height_q - FRAME_HEIGHT_W'(1);
    end
  end

  // position counters
  logic [ColW-1:0]           col_q, col_d, c_now;
  logic [FRAME_HEIGHT_W-1:0] row_q, row_d, r_now;
  logic                      in_acc, produce, last_now;

  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    c_now    = start_of_frame_i ? '0 : col_q;
    r_now    = start_of_frame_i ? '0 : row_q;
    produce  = (r_now >= FRAME_HEIGHT_W'(2)) && (r_now <= h_last) &&
               (c_now >= ColW'(2)) && (c_now <= w_last);
    last_now = (r_now == h_last) && (c_now == w_last);
    if (c_now >= w_last) begin
      col_d = '0;
      row_d = (r_now >= h_last) ? '0 : r_now + FRAME_HEIGHT_W'(1);
    end else begin
      col_d = c_now + ColW'(1);
      row_d = r_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line RAM stage: read at accept, write back in the following cycle
  logic                  s1_valid_q, s1_res_q, s1_last_q;
  logic [ColW-1:0]       s1_addr_q;
  logic [PIXEL_BITS-1:0] s1_px_q;
  logic                  fwd_q;
  logic [LineW-1:0]      fwd_data_q;
  logic [LineW-1:0]      line_rd, line_sel, line_wr;

  c3f_ram #(
    .WIDTH(LineW),
    .DEPTH(MAX_LINE_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (line_wr),
    .re_i    (in_acc),
    .raddr_i (c_now),
    .rdata_o (line_rd)
  );

  assign line_sel = fwd_q ? fwd_data_q : line_rd;
  assign line_wr  = {line_sel[PIXEL_BITS-1:0], s1_px_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      s1_res_q   <= in_acc && produce;
      fwd_q      <= in_acc && s1_valid_q && (s1_addr_q == c_now);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q  <= last_now;
    s1_addr_q  <= c_now;
    s1_px_q    <= pixel_i;
    fwd_data_q <= line_wr;
  end

  // window shift
  logic [PIXEL_BITS-1:0] win_q [WIN_SIZE];
  logic [PIXEL_BITS-1:0] win_d [WIN_SIZE];
  logic                  res2_q, last2_q;

  always_comb begin
    win_d = win_q;
    for (int j = 0; j < WIN_DIM; j++) begin
      win_d[j*WIN_DIM]     = win_q[j*WIN_DIM + 1];
      win_d[j*WIN_DIM + 1] = win_q[j*WIN_DIM + 2];
    end
    win_d[2] = line_sel[LineW-1:PIXEL_BITS];
    win_d[5] = line_sel[PIXEL_BITS-1:0];
    win_d[8] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN_SIZE; k++) begin
        win_q[k] <= '0;
      end
      res2_q <= 1'b0;
    end else begin
      if (s1_valid_q) begin
        win_q <= win_d;
      end
      res2_q <= s1_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    last2_q <= s1_last_q;
  end

  // products, row sums, total
  logic signed [ProdW-1:0] prod_d [WIN_SIZE];
  logic signed [ProdW-1:0] prod_q [WIN_SIZE];
  logic signed [RowW-1:0]  rsum_q [WIN_DIM];
  logic signed [SumW-1:0]  total;
  logic [SumW+OUT_W-1:0]   total_ext;
  logic                    res3_q, res4_q, last3_q, last4_q;

  always_comb begin
    for (int j = 0; j < WIN_DIM; j++) begin
      for (int i = 0; i < WIN_DIM; i++) begin
        prod_d[j*WIN_DIM + i] = $signed({1'b0, win_q[j*WIN_DIM + i]}) *
                                mask_coef(mask_q[j], 2'(i));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res3_q <= 1'b0;
      res4_q <= 1'b0;
    end else begin
      res3_q <= res2_q;
      res4_q <= res3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    last3_q <= last2_q;
    last4_q <= last3_q;
    for (int j = 0; j < WIN_DIM; j++) begin
      rsum_q[j] <= RowW'(prod_q[j*WIN_DIM]) + RowW'(prod_q[j*WIN_DIM + 1]) +
                   RowW'(prod_q[j*WIN_DIM + 2]);
    end
  end

  assign total     = SumW'(rsum_q[0]) + SumW'(rsum_q[1]) + SumW'(rsum_q[2]);
  assign total_ext = {{OUT_W{total[SumW-1]}}, total};

  // result queue
  logic [OUT_W-1:0]      fifo_val_q  [FIFO_DEPTH];
  logic                  fifo_last_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q, occ;
  logic                  push, pop;

  assign push        = res4_q;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;

  assign filtered_value_o = fifo_val_q[rd_ptr_q];
  assign last_of_frame_o  = fifo_last_q[rd_ptr_q];

  // results in flight count against the free queue entries
  assign occ = cnt_q + FIFO_CNT_W'(s1_res_q) + FIFO_CNT_W'(res2_q) +
               FIFO_CNT_W'(res3_q) + FIFO_CNT_W'(res4_q);
  assign in_ready_o = (occ < FIFO_CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_val_q[wr_ptr_q]  <= total_ext[OUT_W-1:0];
      fifo_last_q[wr_ptr_q] <= last4_q;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/c3f_checker.sv -----
// c3f_checker: port-level assertions for the 3x3 image convolution filter
// depends on c3f_pkg; bound to conv3x3_image_filter_top
`default_nettype none

module c3f_checker
  import c3f_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [OUT_W-1:0] filtered_value_o,
  input wire logic             last_of_frame_o
);

  // a result held back stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_value_o) &&
                                    $stable(last_of_frame_o))
    else $error("result changed while stalled");

  // input only stalls when results are waiting
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // a result surfacing on an empty output comes from an accepted item
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 5))
    else $error("result without matching item");

endmodule

bind conv3x3_image_filter_top c3f_checker u_c3f_checker (.*);

`default_nettype wire

// ----- tb/sv/conv3x3_image_filter_checker.sv -----
// conv3x3_image_filter_checker: watches the config, pixel and result channels of the 3x3 filter,
// predicts every interior-pixel sum from its own copy of line stores, window and registers
// depends on c3f_pkg; instantiated beside the block by the testbench top

module conv3x3_image_filter_checker
  import c3f_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int PIXEL_BITS     = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  input  wire logic                   cfg_ready_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_ready_i,
  input  wire logic [PIXEL_BITS-1:0]  pixel_i,
  input  wire logic                   start_of_frame_i,
  input  wire logic                   out_valid_i,
  input  wire logic                   out_ready_i,
  input  wire logic [OUT_W-1:0]       filtered_value_i,
  input  wire logic                   last_of_frame_i,
  output int                          mismatches_o,
  output int                          pending_o
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             last;
  } filter_sum_t;

  filter_sum_t pending_sums[$];
  filter_sum_t want;

  logic [FRAME_WIDTH_W-1:0]  frame_w;
  logic [FRAME_HEIGHT_W-1:0] frame_h;
  logic [MASK_W-1:0]         coef_rows [WIN_DIM];

  logic [PIXEL_BITS-1:0] older_line [MAX_LINE_WIDTH];
  logic [PIXEL_BITS-1:0] newer_line [MAX_LINE_WIDTH];
  logic [PIXEL_BITS-1:0] window [WIN_SIZE];
  int unsigned           col_pos;
  int unsigned           line_pos;

  // shift one pixel into the window and queue the weighted sum when the centre is interior
  task automatic weigh_neighborhood(input logic [PIXEL_BITS-1:0] pix, input logic sof);
    int unsigned             w;
    int unsigned             h;
    int unsigned             c;
    int                      sum;
    logic signed [COEF_W-1:0] coef;
    filter_sum_t             res;
    w = frame_w;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_LINE_WIDTH) w = MAX_LINE_WIDTH;
    h = frame_h;
    if (h < MIN_DIM) h = MIN_DIM;
    if (sof) begin
      col_pos = 0;
      line_pos = 0;
    end
    c = col_pos % MAX_LINE_WIDTH;
    for (int k = 0; k < WIN_DIM; k++) begin
      window[k*WIN_DIM]     = window[k*WIN_DIM + 1];
      window[k*WIN_DIM + 1] = window[k*WIN_DIM + 2];
    end
    window[WIN_DIM - 1]     = older_line[c];
    window[2*WIN_DIM - 1]   = newer_line[c];
    window[WIN_SIZE - 1]    = pix;
    older_line[c] = newer_line[c];
    newer_line[c] = pix;
    if (line_pos >= 2 && line_pos <= h - 1 && col_pos >= 2 && col_pos <= w - 1) begin
      sum = 0;
      for (int k = 0; k < WIN_SIZE; k++) begin
        coef = coef_rows[k / WIN_DIM][(k % WIN_DIM)*COEF_W +: COEF_W];
        sum += int'(window[k]) * int'(coef);
      end
      res.value = OUT_W'(sum);
      res.last  = (line_pos == h - 1 && col_pos == w - 1);
      pending_sums.push_back(res);
    end
    if (col_pos >= w - 1) begin
      col_pos = 0;
      if (line_pos >= h - 1) begin
        line_pos = 0;
      end else begin
        line_pos = (line_pos + 1) & 16'hffff;
      end
    end else begin
      col_pos++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_sums.delete();
      frame_w = FRAME_WIDTH_RESET;
      frame_h = FRAME_HEIGHT_RESET;
      for (int k = 0; k < WIN_DIM; k++) coef_rows[k] = MASK_RESET;
      for (int k = 0; k < WIN_SIZE; k++) window[k] = '0;
      for (int k = 0; k < MAX_LINE_WIDTH; k++) begin
        older_line[k] = '0;
        newer_line[k] = '0;
      end
      col_pos = 0;
      line_pos = 0;
      mismatches_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_sums.size() == 0) begin
          if (mismatches_o < MAX_REPORTS)
            $display("unexpected result: value %0d last %0b",
                     $signed(filtered_value_i), last_of_frame_i);
          mismatches_o++;
        end else begin
          want = pending_sums.pop_front();
          if (filtered_value_i !== want.value || last_of_frame_i !== want.last) begin
            if (mismatches_o < MAX_REPORTS)
              $display("result mismatch: expected value %0d last %0b, got value %0d last %0b",
                       $signed(want.value), want.last, $signed(filtered_value_i),
                       last_of_frame_i);
            mismatches_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH:  frame_w = cfg_data_i[FRAME_WIDTH_W-1:0];
          REG_FRAME_HEIGHT: frame_h = cfg_data_i[FRAME_HEIGHT_W-1:0];
          REG_MASK_TOP:     coef_rows[0] = cfg_data_i[MASK_W-1:0];
          REG_MASK_MIDDLE:  coef_rows[1] = cfg_data_i[MASK_W-1:0];
          REG_MASK_BOTTOM:  coef_rows[2] = cfg_data_i[MASK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) weigh_neighborhood(pixel_i, start_of_frame_i);
      pending_o = pending_sums.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: drives pixel frames and register writes into conv3x3_image_filter_top with random
// idling on both sides and gives the verdict from the checker's mismatch count
// depends on c3f_pkg, conv3x3_image_filter_top and conv3x3_image_filter_checker

module testbench;
  import c3f_pkg::*;

  localparam int MAX_LINE_WIDTH = 1024;
  localparam int PIXEL_BITS     = 8;
  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 200;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int QUIET_ITEMS    = 300;
  localparam int HOLD_PHASE     = 2;
  localparam int PAUSE_PHASE    = 1;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  localparam logic [PIXEL_BITS-1:0] PIXEL_MAX          = '1;
  localparam logic [COEF_W-1:0]     COEF_MOST_NEGATIVE = 8'h80;
  localparam logic [COEF_W-1:0]     COEF_MOST_POSITIVE = 8'h7f;

  logic                   clk_i       = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_valid   = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   in_valid    = 1'b0;
  logic [PIXEL_BITS-1:0]  pixel       = '0;
  logic                   frame_start = 1'b0;
  logic                   out_ready   = 1'b0;
  wire logic              cfg_ready;
  wire logic              in_ready;
  wire logic              out_valid;
  wire logic [OUT_W-1:0]  filtered_value;
  wire logic              last_of_frame;
  int                     mismatches;
  int                     pending_results;

  bit quiet     = 1'b0;
  bit tx_gaps   = 1'b1;
  bit long_hold = 1'b0;

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  conv3x3_image_filter_top #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH),
    .PIXEL_BITS    (PIXEL_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .pixel_i         (pixel),
    .start_of_frame_i(frame_start),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .filtered_value_o(filtered_value),
    .last_of_frame_o (last_of_frame)
  );

  conv3x3_image_filter_checker #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH),
    .PIXEL_BITS    (PIXEL_BITS)
  ) result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .pixel_i         (pixel),
    .start_of_frame_i(frame_start),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .filtered_value_i(filtered_value),
    .last_of_frame_i (last_of_frame),
    .mismatches_o    (mismatches),
    .pending_o       (pending_results)
  );

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  task automatic send_pixel(input logic [PIXEL_BITS-1:0] value, input logic sof);
    int gap;
    if (!quiet && tx_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    pixel       <= value;
    frame_start <= sof;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // stop offering items until every queued sum is out and the pipeline is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(0, 5))
      0:       return MASK_RESET;
      1:       return {WIN_DIM{COEF_MOST_NEGATIVE}};
      2:       return {WIN_DIM{COEF_MOST_POSITIVE}};
      3:       return '0;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  // result side: random stall bursts, calm stretches, and one long hold-off
  initial begin : result_sink
    int unsigned calm_left;
    int          burst;
    calm_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk_i);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && calm_left == 0 && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (burst) @(negedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 40) == 0) begin
          calm_left = $urandom_range(20, 80);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned           frame_w_raw;
    int unsigned           frame_h_raw;
    int unsigned           eff_w;
    int unsigned           eff_h;
    int unsigned           frame_len;
    int unsigned           random_sent;
    int unsigned           safe_w;
    int                    phase;
    int                    count;
    int                    pause_at;
    bit                    aligned;
    logic                  sof;
    logic [PIXEL_BITS-1:0] value;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // reset sizes and box sum, up to the first interior pixel
    for (int i = 0; i < 2*FRAME_WIDTH_RESET + MIN_DIM; i++) send_pixel(PIXEL_MAX, i == 0);
    // widest line whose columns have both line stores written
    safe_w = FRAME_WIDTH_RESET;

    // smallest frame, all coefficients most negative, brightest pixels
    drain_results();
    frame_w_raw = MIN_DIM;
    frame_h_raw = MIN_DIM;
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(frame_w_raw));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(frame_h_raw));
    write_reg(REG_MASK_TOP, {WIN_DIM{COEF_MOST_NEGATIVE}});
    write_reg(REG_MASK_MIDDLE, {WIN_DIM{COEF_MOST_NEGATIVE}});
    write_reg(REG_MASK_BOTTOM, {WIN_DIM{COEF_MOST_NEGATIVE}});
    cfg_valid <= 1'b0;
    for (int i = 0; i < MIN_DIM*MIN_DIM; i++) send_pixel(PIXEL_MAX, i == 0);

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      quiet = (random_sent + QUIET_ITEMS >= RANDOM_ITEMS);
      if (!quiet) drain_results();
      tx_gaps = ($urandom_range(0, 3) != 0);
      if (phase == HOLD_PHASE) begin
        frame_w_raw = 4;
        frame_h_raw = 4;
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(frame_w_raw));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(frame_h_raw));
        long_hold = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 9))
            0:       frame_w_raw = $urandom_range(0, MIN_DIM - 1);
            1:       frame_w_raw = $urandom_range(MAX_LINE_WIDTH, (1 << FRAME_WIDTH_W) - 1);
            2:       frame_w_raw = $urandom_range(11, 40);
            default: frame_w_raw = $urandom_range(MIN_DIM, 10);
          endcase
          write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(frame_w_raw));
        end
        if ($urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 9))
            0:       frame_h_raw = $urandom_range(0, MIN_DIM - 1);
            1:       frame_h_raw = $urandom_range(0, 1) ? (1 << FRAME_HEIGHT_W) - 1
                                                        : $urandom_range(9, 65535);
            default: frame_h_raw = $urandom_range(MIN_DIM, 8);
          endcase
          write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(frame_h_raw));
        end
        if ($urandom_range(0, 2) != 0) write_reg(REG_MASK_TOP, pick_mask());
        if ($urandom_range(0, 2) != 0) write_reg(REG_MASK_MIDDLE, pick_mask());
        if ($urandom_range(0, 2) != 0) write_reg(REG_MASK_BOTTOM, pick_mask());
        // unused register index, must change nothing
        if ($urandom_range(0, 7) == 0)
          write_reg(CFG_INDEX_W'($urandom_range(int'(REG_MASK_BOTTOM) + 1,
                                                (1 << CFG_INDEX_W) - 1)),
                    CFG_DATA_W'($urandom));
      end
      cfg_valid <= 1'b0;

      eff_w = (frame_w_raw < MIN_DIM) ? MIN_DIM :
              (frame_w_raw > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : frame_w_raw;
      eff_h = (frame_h_raw < MIN_DIM) ? MIN_DIM : frame_h_raw;
      frame_len = eff_w * eff_h;
      if (phase == HOLD_PHASE) begin
        count = 300;
      end else if (frame_len <= 160) begin
        count = frame_len * $urandom_range(1, 3) + $urandom_range(0, eff_w);
      end else begin
        count = $urandom_range(30, 250);
      end
      aligned  = (phase == HOLD_PHASE) || ($urandom_range(0, 3) != 0);
      // a line wider than any filled so far starts a fresh frame
      if (eff_w > safe_w) aligned = 1'b1;
      pause_at = (phase == PAUSE_PHASE) ? count / 2 : -1;

      for (int i = 0; i < count; i++) begin
        if (i == pause_at) drain_results();
        if (aligned && i % frame_len == 0) begin
          sof = (i == 0) || ($urandom_range(0, 1) == 1);
        end else begin
          sof = !aligned && ($urandom_range(0, 15) == 0);
        end
        case ($urandom_range(0, 7))
          0:       value = '0;
          1:       value = PIXEL_MAX;
          default: value = PIXEL_BITS'($urandom);
        endcase
        send_pixel(value, sof);
      end
      if (eff_w > safe_w && count >= 2*eff_w) safe_w = eff_w;
      random_sent += count;
      phase++;
    end

    drain_results();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/c3f_pkg.sv
hdl/c3f_ram.sv
hdl/conv3x3_image_filter_top.sv
hdl/c3f_checker.sv
tb/sv/conv3x3_image_filter_checker.sv
tb/sv/testbench.sv
